// File: rtl/plic_pkg.sv
// Package with shared constants, command and status codes, and types of the packed list unit.
`default_nettype none

package plic_pkg;

   localparam int DefaultDepth    = 64;
   localparam int DefaultItemBits = 31;
   localparam int OpBits          = 3;
   localparam int StatusBits      = 2;

   localparam logic [OpBits-1:0] OpInsertFirst = 3'd0;
   localparam logic [OpBits-1:0] OpInsertAt    = 3'd1;
   localparam logic [OpBits-1:0] OpInsertLast  = 3'd2;
   localparam logic [OpBits-1:0] OpDeleteFirst = 3'd3;
   localparam logic [OpBits-1:0] OpDeleteAt    = 3'd4;
   localparam logic [OpBits-1:0] OpDeleteLast  = 3'd5;

   localparam logic [StatusBits-1:0] StDone  = 2'd0;
   localparam logic [StatusBits-1:0] StFull  = 2'd1;
   localparam logic [StatusBits-1:0] StEmpty = 2'd2;
   localparam logic [StatusBits-1:0] StRange = 2'd3;

   typedef struct packed {
      logic insert;
      logic remove;
   } shift_ctl_type;

endpackage

`default_nettype wire

// File: rtl/plic_req_if.sv
// Command channel interface of the packed list unit.
`default_nettype none

interface plic_req_if #(
   parameter int ITEM_BITS = plic_pkg::DefaultItemBits,
   parameter int POS_BITS  = $clog2(plic_pkg::DefaultDepth)
);
   logic                        valid;
   logic                        ready;
   logic [plic_pkg::OpBits-1:0] op;
   logic [ITEM_BITS-1:0]        value;
   logic [POS_BITS-1:0]         position;

   modport source (output valid, output op, output value, output position, input ready);
   modport sink (input valid, input op, input value, input position, output ready);
endinterface

`default_nettype wire

// File: rtl/plic_rsp_if.sv
// Result channel interface of the packed list unit.
`default_nettype none

interface plic_rsp_if #(
   parameter int ITEM_BITS  = plic_pkg::DefaultItemBits,
   parameter int COUNT_BITS = $clog2(plic_pkg::DefaultDepth + 1)
);
   logic                            valid;
   logic                            ready;
   logic [ITEM_BITS-1:0]            removed_value;
   logic [COUNT_BITS-1:0]           count;
   logic [plic_pkg::StatusBits-1:0] status;

   modport source (output valid, output removed_value, output count, output status,
                   input ready);
   modport sink (input valid, input removed_value, input count, input status,
                 output ready);
endinterface

`default_nettype wire

// File: rtl/plic_cell.sv
// One slot of the packed list: shifts up, shifts down or loads the new item.
`default_nettype none

module plic_cell #(
   parameter int ITEM_BITS = plic_pkg::DefaultItemBits,
   parameter int POS_BITS  = $clog2(plic_pkg::DefaultDepth),
   parameter int INDEX     = 0
) (
   input  wire logic                    clock,
   input  wire plic_pkg::shift_ctl_type ctl,
   input  wire logic [POS_BITS-1:0]     at,
   input  wire logic [ITEM_BITS-1:0]    value,
   input  wire logic [ITEM_BITS-1:0]    left_data,
   input  wire logic [ITEM_BITS-1:0]    right_data,
   output logic [ITEM_BITS-1:0]         data,
   output logic [ITEM_BITS-1:0]         tap
);
   localparam logic [POS_BITS-1:0] Index = POS_BITS'(INDEX);

   logic [ITEM_BITS-1:0] data_ff;
   logic [ITEM_BITS-1:0] data_in;
   logic                 hit;
   logic                 above;

   assign hit   = (at == Index);
   assign above = (Index > at);

   always_comb begin
      data_in = data_ff;
      priority if (ctl.insert && hit) begin
         data_in = value;
      end else if (ctl.insert && above) begin
         data_in = left_data;
      end else if (ctl.remove && (hit || above)) begin
         data_in = right_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign tap  = hit ? data_ff : '0;

endmodule

`default_nettype wire

// File: rtl/packed_list_insert_delete_unit.sv
// Top level of the packed list unit: command decode, row of slot cells and result register.
// The result of an item is registered and presented in the cycle after it is accepted.
// Throughput: one item per cycle unless stalled; cells at and above the position shift.
// Back pressure: a new item is taken while the result register is empty or being drained.
// Reset clears the element count and the result valid flag; slot contents are not cleared.
`default_nettype none

module packed_list_insert_delete_unit #(
   parameter int DEPTH     = plic_pkg::DefaultDepth,
   parameter int ITEM_BITS = plic_pkg::DefaultItemBits
) (
   input wire logic   clock,
   input wire logic   reset,
   plic_req_if.sink   req_chan,
   plic_rsp_if.source rsp_chan
);
   localparam int PosBits   = $clog2(DEPTH);
   localparam int CountBits = $clog2(DEPTH + 1);

   logic [CountBits-1:0]            fill_ff;
   logic [CountBits-1:0]            fill_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [ITEM_BITS-1:0]            removed_ff;
   logic [CountBits-1:0]            count_ff;
   logic [plic_pkg::StatusBits-1:0] status_ff;

   logic                            accept;
   logic                            full;
   logic                            empty;
   logic [CountBits-1:0]            pos_cnt;
   logic [CountBits-1:0]            at_cnt;
   logic [PosBits-1:0]              at;
   logic                            do_insert;
   logic                            do_delete;
   logic [plic_pkg::StatusBits-1:0] status;
   plic_pkg::shift_ctl_type         ctl;
   logic [ITEM_BITS-1:0]            removed_sel;
   logic [ITEM_BITS-1:0]            removed_in;

   logic [ITEM_BITS-1:0] cell_data [DEPTH];
   logic [ITEM_BITS-1:0] cell_tap  [DEPTH];

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign full    = (fill_ff == CountBits'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign pos_cnt = CountBits'(req_chan.position);

   always_comb begin
      do_insert = 1'b0;
      do_delete = 1'b0;
      status    = plic_pkg::StDone;
      at_cnt    = '0;
      unique case (req_chan.op)
         plic_pkg::OpInsertFirst, plic_pkg::OpInsertLast: begin
            if (full) begin
               status = plic_pkg::StFull;
            end else begin
               do_insert = 1'b1;
               at_cnt    = (req_chan.op == plic_pkg::OpInsertLast) ? fill_ff : '0;
            end
         end
         plic_pkg::OpInsertAt: begin
            priority if (full) begin
               status = plic_pkg::StFull;
            end else if (empty) begin
               status = plic_pkg::StEmpty;
            end else if (pos_cnt > fill_ff) begin
               status = plic_pkg::StRange;
            end else begin
               do_insert = 1'b1;
               at_cnt    = pos_cnt;
            end
         end
         plic_pkg::OpDeleteFirst, plic_pkg::OpDeleteLast: begin
            if (empty) begin
               status = plic_pkg::StEmpty;
            end else begin
               do_delete = 1'b1;
               at_cnt    = (req_chan.op == plic_pkg::OpDeleteLast) ? fill_ff - 1'b1 : '0;
            end
         end
         plic_pkg::OpDeleteAt: begin
            priority if (empty) begin
               status = plic_pkg::StEmpty;
            end else if (pos_cnt >= fill_ff) begin
               status = plic_pkg::StRange;
            end else begin
               do_delete = 1'b1;
               at_cnt    = pos_cnt;
            end
         end
         default: begin
         end
      endcase
   end

   assign at         = at_cnt[PosBits-1:0];
   assign ctl.insert = accept && do_insert;
   assign ctl.remove = accept && do_delete;

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [ITEM_BITS-1:0] left_data;
      logic [ITEM_BITS-1:0] right_data;

      if (k == 0) begin : g_first
         assign left_data = req_chan.value;
      end else begin : g_left
         assign left_data = cell_data[k-1];
      end

      if (k == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_right
         assign right_data = cell_data[k+1];
      end

      plic_cell #(
         .ITEM_BITS (ITEM_BITS),
         .POS_BITS  (PosBits),
         .INDEX     (k)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .at         (at),
         .value      (req_chan.value),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[k]),
         .tap        (cell_tap[k])
      );
   end

   // Only the addressed cell drives a nonzero tap, so an OR over all taps selects it.
   always_comb begin
      removed_sel = '0;
      for (int k = 0; k < DEPTH; k++) begin
         removed_sel = removed_sel | cell_tap[k];
      end
   end

   assign removed_in = do_delete ? removed_sel : '0;

   always_comb begin
      fill_in = fill_ff;
      priority if (ctl.insert) begin
         fill_in = fill_ff + 1'b1;
      end else if (ctl.remove) begin
         fill_in = fill_ff - 1'b1;
      end else begin
         fill_in = fill_ff;
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         removed_ff <= removed_in;
         count_ff   <= fill_in;
         status_ff  <= status;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.removed_value = removed_ff;
   assign rsp_chan.count         = count_ff;
   assign rsp_chan.status        = status_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CountBits'(DEPTH))
      else $error("Element count exceeds the list depth.");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctl.insert |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("An accepted insert did not grow the list by one.");

   a_delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      ctl.remove |=> fill_ff == $past(fill_ff) - 1'b1)
      else $error("An accepted delete did not shrink the list by one.");

   a_removed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != plic_pkg::StDone |-> removed_ff == '0)
      else $error("A rejected item reports a nonzero removed value.");

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      accept |=> count_ff == fill_ff)
      else $error("Reported count differs from the element count.");

endmodule

`default_nettype wire
